FILE: rtl/tcw_pkg.sv
package tcw_pkg;

  localparam int DEF_COLS    = 80;
  localparam int DEF_ROWS    = 25;
  localparam int QUEUE_DEPTH = 2;

  localparam int CHAR_W     = 8;
  localparam int ATTR_W     = 8;
  localparam int CMD_W      = 2;
  localparam int OP_W       = 3;
  localparam int FG_W       = 4;
  localparam int BG_W       = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  // command codes on the input channel
  localparam logic [CMD_W-1:0] CMD_CHAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RAW  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MOVE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FG    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;
  localparam logic [FG_W-1:0]   FG_RESET   = 4'd7;
  localparam logic [BG_W-1:0]   BG_RESET   = 3'd0;

  // classified operation carried from front to back
  typedef enum logic [OP_W-1:0] {
    OP_NEWLINE   = 3'd0,
    OP_BACKSPACE = 3'd1,
    OP_WRITE     = 3'd2,
    OP_MOVE      = 3'd3,
    OP_READ      = 3'd4
  } op_t;

endpackage

FILE: rtl/tcw_ram.sv
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/tcw_front.sv
module tcw_front import tcw_pkg::*; #(
  parameter int COLS = DEF_COLS,
  parameter int ROWS = DEF_ROWS,
  localparam int COL_W = $clog2(COLS),
  localparam int ROW_W = $clog2(ROWS),
  localparam int ITEM_W = OP_W + CHAR_W + COL_W + ROW_W
) (
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CMD_W-1:0]  command,
  input  logic [CHAR_W-1:0] char_code,
  input  logic [COL_W-1:0]  col,
  input  logic [ROW_W-1:0]  row,
  input  logic              init_busy,
  output logic              push_valid,
  input  logic              push_ready,
  output logic [ITEM_W-1:0] push_data
);

  typedef struct packed {
    op_t               op;
    logic [CHAR_W-1:0] code;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
  } item_t;

  localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLS - 1);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

  item_t item;

  // no beat is taken while the screen is being cleared after reset
  assign in_ready   = push_ready && !init_busy;
  assign push_valid = in_valid && !init_busy;
  assign push_data  = item;

  always_comb begin
    item.code = char_code;
    item.col  = (col > LAST_COL) ? LAST_COL : col;
    item.row  = (row > LAST_ROW) ? LAST_ROW : row;
    case (command)
      CMD_CHAR: begin
        if (char_code == CHAR_NL) begin
          item.op = OP_NEWLINE;
        end else if (char_code == CHAR_BS) begin
          item.op = OP_BACKSPACE;
        end else begin
          item.op = OP_WRITE;
        end
      end
      CMD_RAW:  item.op = OP_WRITE;
      CMD_MOVE: item.op = OP_MOVE;
      CMD_READ: item.op = OP_READ;
      default:  item.op = OP_READ;
    endcase
  end

endmodule

FILE: rtl/tcw_fifo.sv
module tcw_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int PTR_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != FULL_CNT);
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/tcw_back.sv
module tcw_back import tcw_pkg::*; #(
  parameter int COLS = DEF_COLS,
  parameter int ROWS = DEF_ROWS,
  localparam int COL_W = $clog2(COLS),
  localparam int ROW_W = $clog2(ROWS),
  localparam int ITEM_W = OP_W + CHAR_W + COL_W + ROW_W
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  pop_valid,
  output logic                  pop_ready,
  input  logic [ITEM_W-1:0]     pop_data,
  output logic                  init_busy,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COL_W-1:0]      cursor_col,
  output logic [ROW_W-1:0]      cursor_row,
  output logic [CHAR_W-1:0]     cell_char,
  output logic [ATTR_W-1:0]     cell_attr
);

  typedef struct packed {
    op_t               op;
    logic [CHAR_W-1:0] code;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
  } item_t;

  typedef enum logic [3:0] {
    S_INIT  = 4'b0001,
    S_IDLE  = 4'b0010,
    S_READ  = 4'b0100,
    S_CLEAR = 4'b1000
  } state_t;

  localparam int CELLS = COLS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int RAM_W = CHAR_W + ATTR_W;

  localparam logic [COL_W-1:0] LAST_COL  = COL_W'(COLS - 1);
  localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(ROWS - 1);
  localparam logic [AW-1:0]    LAST_ADDR = AW'(CELLS - 1);
  localparam logic [AW-1:0]    COLS_A    = AW'(COLS);
  localparam logic [ROW_W:0]   ROWS_EXT  = (ROW_W + 1)'(ROWS);

  state_t            state;
  item_t             item;
  logic              take;
  logic [COL_W-1:0]  cursor_x;
  logic [ROW_W-1:0]  cursor_y;
  logic [COL_W-1:0]  cursor_x_next;
  logic [ROW_W-1:0]  cursor_y_next;
  logic              scroll;
  logic              line_feed;
  logic [ROW_W-1:0]  top;
  logic [FG_W-1:0]   fg;
  logic [BG_W-1:0]   bg;
  logic              blink;
  logic [ATTR_W-1:0] cur_attr;
  logic [AW-1:0]     init_addr;
  logic [ROW_W-1:0]  clear_row;
  logic [COL_W-1:0]  clear_col;
  logic [ATTR_W-1:0] clear_attr;
  logic [ROW_W-1:0]  acc_row;
  logic [COL_W-1:0]  acc_col;
  logic [ROW_W:0]    row_sum;
  logic [ROW_W-1:0]  phys_row;
  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [RAM_W-1:0]  ram_wdata;
  logic [RAM_W-1:0]  ram_rdata;

  assign item      = item_t'(pop_data);
  assign pop_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign take      = pop_valid && pop_ready;
  assign init_busy = (state == S_INIT);
  assign cur_attr  = {blink, bg, fg};

  // cursor update for the item at the head of the queue
  always_comb begin
    cursor_x_next = cursor_x;
    cursor_y_next = cursor_y;
    line_feed     = 1'b0;
    scroll        = 1'b0;
    case (item.op)
      OP_NEWLINE:   line_feed = 1'b1;
      OP_BACKSPACE: begin
        if (cursor_x != '0) begin
          cursor_x_next = cursor_x - 1'b1;
        end
      end
      OP_WRITE: begin
        if (cursor_x == LAST_COL) begin
          line_feed = 1'b1;
        end else begin
          cursor_x_next = cursor_x + 1'b1;
        end
      end
      OP_MOVE: begin
        cursor_x_next = item.col;
        cursor_y_next = item.row;
      end
      default: ;
    endcase
    if (line_feed) begin
      cursor_x_next = '0;
      if (cursor_y == LAST_ROW) begin
        scroll = 1'b1;
      end else begin
        cursor_y_next = cursor_y + 1'b1;
      end
    end
  end

  // screen rows are a ring, top names the physical row shown first
  always_comb begin
    acc_row = (item.op == OP_READ) ? item.row : cursor_y;
    acc_col = (item.op == OP_READ) ? item.col : cursor_x;
    row_sum = {1'b0, acc_row} + {1'b0, top};
    if (state == S_CLEAR) begin
      phys_row = clear_row;
      acc_col  = clear_col;
    end else if (row_sum >= ROWS_EXT) begin
      phys_row = ROW_W'(row_sum - ROWS_EXT);
    end else begin
      phys_row = ROW_W'(row_sum);
    end
    if (state == S_INIT) begin
      ram_addr = init_addr;
    end else begin
      ram_addr = AW'(phys_row) * COLS_A + AW'(acc_col);
    end
  end

  always_comb begin
    ram_we = (state == S_INIT) || (state == S_CLEAR) || (take && (item.op == OP_WRITE));
    if (state == S_INIT) begin
      ram_wdata = {CHAR_SPACE, ATTR_RESET};
    end else if (state == S_CLEAR) begin
      ram_wdata = {CHAR_SPACE, clear_attr};
    end else begin
      ram_wdata = {item.code, cur_attr};
    end
  end

  tcw_ram #(
    .WIDTH(RAM_W),
    .DEPTH(CELLS)
  ) u_screen (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      init_addr <= '0;
      cursor_x  <= '0;
      cursor_y  <= '0;
      top       <= '0;
      fg        <= FG_RESET;
      bg        <= BG_RESET;
      blink     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FG:    fg    <= cfg_data[FG_W-1:0];
          CFG_BG:    bg    <= cfg_data[BG_W-1:0];
          CFG_BLINK: blink <= cfg_data[0];
          default: ;
        endcase
      end
      // a result loaded this cycle takes the place of the one leaving
      if (out_valid && out_ready && !(take && (item.op != OP_READ))) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          init_addr <= init_addr + 1'b1;
          if (init_addr == LAST_ADDR) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (take) begin
            if (item.op == OP_READ) begin
              state <= S_READ;
            end else begin
              cursor_x   <= cursor_x_next;
              cursor_y   <= cursor_y_next;
              out_valid  <= 1'b1;
              cursor_col <= cursor_x_next;
              cursor_row <= cursor_y_next;
              cell_char  <= '0;
              cell_attr  <= '0;
              if (scroll) begin
                top        <= (top == LAST_ROW) ? '0 : top + 1'b1;
                clear_row  <= top;
                clear_col  <= '0;
                clear_attr <= cur_attr;
                state      <= S_CLEAR;
              end
            end
          end
        end
        S_READ: begin
          out_valid  <= 1'b1;
          cursor_col <= cursor_x;
          cursor_row <= cursor_y;
          cell_char  <= ram_rdata[RAM_W-1:ATTR_W];
          cell_attr  <= ram_rdata[ATTR_W-1:0];
          state      <= S_IDLE;
        end
        S_CLEAR: begin
          clear_col <= clear_col + 1'b1;
          if (clear_col == LAST_COL) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_INIT;
      endcase
    end
  end

endmodule

FILE: rtl/text_console_cursor_writer.sv
// text console writer: a screen of COLS x ROWS character/attribute cells and a cursor
// input channel (in_valid/in_ready): one command beat carries command, char_code, col, row
//   command 0 interprets newline and backspace, 1 writes char_code raw,
//   2 moves the cursor (saturating), 3 reads one cell (saturating coordinates)
// output channel (out_valid/out_ready): exactly one beat per command, with the cursor
//   after the command and, for a read, the cell's character and attribute (zero otherwise)
// config port: cfg_we/cfg_index/cfg_data set fg colour, bg colour and blink, no wait
// a two-entry queue sits between the decoder and the screen engine
// results: a write, move, newline or backspace result is registered as the engine takes the beat,
//   a read result first passes through the read state (registered screen memory read)
// throughput: one command per cycle while results are taken; a read holds the engine in its
//   read state, and a scroll holds it while it blanks the new bottom row, one cell per cycle
// scrolling rotates a row pointer over the screen memory, so no rows are copied
// reset: the screen memory is swept to grey-on-black spaces, all COLS*ROWS cells
//   (2000 at 80x25), during which in_ready stays low; config writes still land
// a stalled receiver holds the result register; the queue absorbs up to two more beats
module text_console_cursor_writer import tcw_pkg::*; #(
  parameter int COLS = DEF_COLS,
  parameter int ROWS = DEF_ROWS,
  localparam int COL_W = $clog2(COLS),
  localparam int ROW_W = $clog2(ROWS)
) (
  input  logic                  clk,
  input  logic                  rst,
  // command channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CMD_W-1:0]      command,
  input  logic [CHAR_W-1:0]     char_code,
  input  logic [COL_W-1:0]      col,
  input  logic [ROW_W-1:0]      row,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COL_W-1:0]      cursor_col,
  output logic [ROW_W-1:0]      cursor_row,
  output logic [CHAR_W-1:0]     cell_char,
  output logic [ATTR_W-1:0]     cell_attr,
  // colour registers
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ITEM_W = OP_W + CHAR_W + COL_W + ROW_W;

  // decoded command beat between decoder and engine
  logic              push_valid;
  logic              push_ready;
  logic [ITEM_W-1:0] push_data;
  logic              pop_valid;
  logic              pop_ready;
  logic [ITEM_W-1:0] pop_data;
  // engine still sweeping the screen after reset
  logic              init_busy;

  // decoder: splits interpreted characters, saturates coordinates
  tcw_front #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .char_code (char_code),
    .col       (col),
    .row       (row),
    .init_busy (init_busy),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data)
  );

  // short queue so decoder and engine stall independently
  tcw_fifo #(
    .WIDTH(ITEM_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  // engine: cursor, screen memory, scroll clearing and result register
  tcw_back #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .init_busy (init_busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cursor_col(cursor_col),
    .cursor_row(cursor_row),
    .cell_char (cell_char),
    .cell_attr (cell_attr)
  );

endmodule

FILE: rtl/tcw_checker.sv
module tcw_checker import tcw_pkg::*; #(
  parameter int COLS = DEF_COLS,
  parameter int ROWS = DEF_ROWS,
  localparam int COL_W = $clog2(COLS),
  localparam int ROW_W = $clog2(ROWS)
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic [CMD_W-1:0]      command,
  input logic [CHAR_W-1:0]     char_code,
  input logic [COL_W-1:0]      col,
  input logic [ROW_W-1:0]      row,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [COL_W-1:0]      cursor_col,
  input logic [ROW_W-1:0]      cursor_row,
  input logic [CHAR_W-1:0]     cell_char,
  input logic [ATTR_W-1:0]     cell_attr
);

  localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLS - 1);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

  // a waiting command beat holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(command) && $stable(char_code)
      && $stable(col) && $stable(row))
    else $error("command beat changed while waiting");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cursor_col) && $stable(cursor_row)
      && $stable(cell_char) && $stable(cell_attr))
    else $error("result beat changed while stalled");

  // the reported cursor never leaves the screen
  a_cursor_bounds: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> cursor_col <= LAST_COL && cursor_row <= LAST_ROW)
    else $error("cursor outside the screen");

  // reset starts the screen sweep: no beat taken, no result pending
  a_reset_sweep: assert property (@(posedge clk)
    rst |=> !in_ready && !out_valid)
    else $error("beat possible right after reset");

endmodule

bind text_console_cursor_writer tcw_checker #(
  .COLS(COLS),
  .ROWS(ROWS)
) u_checker (.*);
